/* rtl/fbfl_pkg.sv */
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and codes for the fixed block free-list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } fsm_t;

  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_ADDR_W    = 1;
  localparam int unsigned NUM_BLOCKS_W  = 9;
  localparam int unsigned IN_INDEX_W    = 8;
  localparam int unsigned FREE_COUNT_W  = 9;
  localparam int unsigned FREE_COUNT_MAX = 511;
  localparam logic [CFG_ADDR_W-1:0] ADDR_NUM_BLOCKS = 1'b0;
  localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RST = 9'd256;

endpackage

/* rtl/fbfl_link_ram.sv */
// ----------------------------------------------------------------------------
// fbfl_link_ram
// Link store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbfl_link_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/fixed_block_free_list_allocator_core.sv */
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// LIFO free-list allocator over a pool of equal blocks numbered by index.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an operation (in_mode, in_block_index) is taken at a
//   clock edge with start high and busy low. Init makes blocks 0..pool-1
//   free, allocate pops the list head (or takes the next unused block when
//   the list is empty), free pushes a block onto the head.
//   Result channel: out_valid is high for one cycle with out_status,
//   out_granted_index and out_free_count; the receiver cannot stall it.
//   Busy is high while a command executes; a new operation is taken only
//   after it, giving the registered link read time before the next pop.
//   Config: APB register num_blocks at address 0, used at the next init.
//   Reset: pool size 0 (allocate reports empty, free reports out of
//   range until init), num_blocks 256, no clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_mode,
  input  logic [fbfl_pkg::IN_INDEX_W-1:0]      in_block_index,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [7:0]                           out_granted_index,
  output logic [fbfl_pkg::FREE_COUNT_W-1:0]    out_free_count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fbfl_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [fbfl_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  import fbfl_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  fsm_t                    state_r, state_nxt;
  mode_t                   mode_r;
  logic [IN_INDEX_W-1:0]   idx_r;
  logic [NUM_BLOCKS_W-1:0] num_blocks_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0] pool_r, pool_nxt;

  logic                    out_valid_r;
  status_t                 status_r, status_nxt;
  logic [IDX_W-1:0]        granted_r, granted_nxt;
  logic [FREE_COUNT_W-1:0] free_count_r, free_count_nxt;

  logic             accept;
  logic             cfg_wr;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [IDX_W-1:0] link_wdata;
  logic [IDX_W-1:0] link_rdata;
  logic [CNT_W-1:0] pool_init;
  logic [CNT_W-1:0] fresh_left;
  logic [CNT_W:0]   total;

  assign accept = start && !busy;
  assign busy   = (state_r == S_EXEC);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NUM_BLOCKS) ? CFG_DATA_W'(num_blocks_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r <= NUM_BLOCKS_RST;
    end else if (cfg_wr && paddr == ADDR_NUM_BLOCKS) begin
      num_blocks_r <= pwdata[NUM_BLOCKS_W-1:0];
    end
  end

  fbfl_link_ram #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IDX_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  assign pool_init = (32'(num_blocks_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                           : CNT_W'(num_blocks_r);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    fresh_nxt   = fresh_r;
    pool_nxt    = pool_r;
    status_nxt  = ST_OK;
    granted_nxt = '0;
    link_we     = 1'b0;
    link_waddr  = IDX_W'(idx_r);
    link_wdata  = (count_r != '0) ? head_r : '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (mode_r)
          MODE_INIT: begin
            pool_nxt  = pool_init;
            count_nxt = '0;
            fresh_nxt = '0;
          end
          MODE_ALLOC: begin
            priority if (count_r != '0) begin
              granted_nxt = head_r;
              head_nxt    = link_rdata;
              count_nxt   = count_r - 1'b1;
            end else if (fresh_r < pool_r) begin
              granted_nxt = IDX_W'(fresh_r);
              fresh_nxt   = fresh_r + 1'b1;
            end else begin
              status_nxt = ST_EMPTY;
            end
          end
          MODE_FREE: begin
            if (32'(idx_r) >= 32'(pool_r)) begin
              status_nxt = ST_RANGE;
            end else begin
              link_we  = 1'b1;
              head_nxt = IDX_W'(idx_r);
              if (32'(count_r) < 32'(MAX_BLOCKS)) begin
                count_nxt = count_r + 1'b1;
              end
            end
          end
          MODE_NOP: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign fresh_left = (fresh_nxt < pool_nxt) ? (pool_nxt - fresh_nxt) : '0;
  assign total      = {1'b0, count_nxt} + {1'b0, fresh_left};
  assign free_count_nxt = (32'(total) > 32'(FREE_COUNT_MAX)) ? FREE_COUNT_W'(FREE_COUNT_MAX)
                                                             : FREE_COUNT_W'(total);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fresh_r     <= '0;
      pool_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      pool_r      <= pool_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      idx_r  <= in_block_index;
    end
    if (state_r == S_EXEC) begin
      status_r     <= status_nxt;
      granted_r    <= granted_nxt;
      free_count_r <= free_count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_index = 8'(granted_r);
  assign out_free_count    = free_count_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted command did not enter execution");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("result strobe missing after execution");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_BLOCKS) && 32'(fresh_r) <= 32'(pool_r))
    else $error("free-list counters out of bounds");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_free_count == '0)
    else $error("empty status with nonzero free count");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_index == '0)
    else $error("granted index on failed operation");
`endif

endmodule

/* tb/fixed_block_free_list_allocator_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core_test
// Self-checking bench for the free-list block allocator. A queue of command
// words and num_blocks writes feeds a falling-edge driver with random gaps;
// a rising-edge monitor predicts each reply from its own copy of the pool
// state and compares every reply word field by field.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core_test;
  import fbfl_pkg::*;

  localparam int POOL_MAX    = 256;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1950;

  typedef struct packed {
    logic [POOL_MAX-1:0][7:0] link;
    logic [8:0]               head;
    logic [8:0]               depth;
    logic [8:0]               fresh;
    logic [8:0]               pool;
    logic [8:0]               cfg_blocks;
  } pool_model_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] granted;
    logic [8:0] free_cnt;
  } alloc_reply_t;

  typedef struct packed {
    logic        is_cfg;
    mode_t       op;
    logic [7:0]  idx;
    logic [31:0] data;
  } alloc_job_t;

  typedef enum logic [2:0] {
    DRV_IDLE, DRV_GAP, DRV_CMD, DRV_DRAIN,
    DRV_WR_SETUP, DRV_WR_ACCESS, DRV_RD_SETUP, DRV_RD_ACCESS
  } drv_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_block_index = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_granted_index;
  logic [8:0]  out_free_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  alloc_job_t   op_backlog[$];
  alloc_reply_t reply_forecast[$];
  logic [7:0]   held_blocks[$];
  pool_model_t  live_pool;
  pool_model_t  plan_pool;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           item_count = 0;
  logic         cmd_taken = 1'b0;
  logic         bus_done = 1'b0;

  drv_state_t   drv_state = DRV_IDLE;
  alloc_job_t   cur_job;
  int           gap_left = 0;
  int           quiet_run = 0;
  logic         start_nx = 1'b0;
  logic [1:0]   mode_nx = '0;
  logic [7:0]   idx_nx = '0;
  logic         psel_nx = 1'b0;
  logic         penable_nx = 1'b0;
  logic         pwrite_nx = 1'b0;
  logic [31:0]  pwdata_nx = '0;

  fixed_block_free_list_allocator_core #(.MAX_BLOCKS(POOL_MAX)) dut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_block_index,
    .out_valid, .out_status, .out_granted_index, .out_free_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  function automatic pool_model_t blank_pool();
    pool_model_t m;
    m.link       = '0;
    m.head       = 9'(POOL_MAX);
    m.depth      = '0;
    m.fresh      = '0;
    m.pool       = '0;
    m.cfg_blocks = NUM_BLOCKS_RST;
    return m;
  endfunction

  function automatic void pool_step(inout pool_model_t m, input mode_t op,
                                    input logic [7:0] idx, output alloc_reply_t r);
    logic [8:0] left;
    logic [9:0] sum;
    r.status  = ST_OK;
    r.granted = '0;
    case (op)
      MODE_INIT: begin
        m.pool  = (m.cfg_blocks > 9'(POOL_MAX)) ? 9'(POOL_MAX) : m.cfg_blocks;
        m.head  = 9'(POOL_MAX);
        m.depth = '0;
        m.fresh = '0;
      end
      MODE_ALLOC: begin
        if (m.depth > 0 && m.head < 9'(POOL_MAX)) begin
          r.granted = m.head[7:0];
          m.head    = {1'b0, m.link[m.head[7:0]]};
          m.depth   = m.depth - 9'd1;
          if (m.depth == 0) m.head = 9'(POOL_MAX);
        end else if (m.fresh < m.pool) begin
          r.granted = m.fresh[7:0];
          m.fresh   = m.fresh + 9'd1;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      MODE_FREE: begin
        if ({1'b0, idx} >= m.pool) begin
          r.status = ST_RANGE;
        end else begin
          m.link[idx] = (m.depth > 0) ? m.head[7:0] : 8'd0;
          m.head      = {1'b0, idx};
          if (m.depth < 9'(POOL_MAX)) m.depth = m.depth + 9'd1;
        end
      end
      default: ;
    endcase
    left = (m.fresh < m.pool) ? m.pool - m.fresh : 9'd0;
    sum  = {1'b0, m.depth} + {1'b0, left};
    r.free_cnt = (sum > 10'(FREE_COUNT_MAX)) ? 9'(FREE_COUNT_MAX) : sum[8:0];
  endfunction

  task automatic add_op(input mode_t op, input logic [7:0] idx);
    alloc_job_t   j;
    alloc_reply_t r;
    int           k;
    j = '{is_cfg: 1'b0, op: op, idx: idx, data: '0};
    op_backlog.push_back(j);
    item_count++;
    pool_step(plan_pool, op, idx, r);
    if (op == MODE_INIT) begin
      held_blocks.delete();
    end else if (op == MODE_ALLOC && r.status == ST_OK) begin
      held_blocks.push_back(r.granted);
    end else if (op == MODE_FREE && r.status == ST_OK) begin
      for (k = 0; k < held_blocks.size(); k++) begin
        if (held_blocks[k] == idx) begin
          held_blocks.delete(k);
          break;
        end
      end
    end
  endtask

  task automatic add_cfg(input logic [8:0] blocks);
    alloc_job_t j;
    j = '{is_cfg: 1'b1, op: MODE_NOP, idx: '0,
          data: ($urandom & 32'hFFFF_FE00) | {23'd0, blocks}};
    op_backlog.push_back(j);
    plan_pool.cfg_blocks = blocks;
  endtask

  task automatic add_fill_phase();
    int         i;
    logic [7:0] stride;
    logic [7:0] offset;
    stride = 8'($urandom_range(0, 127) * 2 + 1);
    offset = 8'($urandom_range(0, 255));
    add_cfg(9'd256);
    add_op(MODE_INIT, 8'($urandom_range(0, 255)));
    for (i = 0; i < POOL_MAX; i++) add_op(MODE_FREE, 8'(i) * stride + offset);
    add_op(MODE_FREE, offset);
    for (i = 0; i < 20; i++) add_op(MODE_ALLOC, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_phase();
    int         n;
    int         w;
    int         i;
    logic [8:0] blocks;
    w = $urandom_range(0, 9);
    case (w)
      0:       blocks = 9'd0;
      1:       blocks = 9'd256;
      2:       blocks = 9'($urandom_range(257, 511));
      3, 4:    blocks = 9'($urandom_range(1, 256));
      default: blocks = 9'($urandom_range(1, 16));
    endcase
    add_cfg(blocks);
    if ($urandom_range(0, 9) != 0) add_op(MODE_INIT, 8'($urandom_range(0, 255)));
    n = $urandom_range(20, 80);
    for (i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 40) begin
        add_op(MODE_ALLOC, 8'($urandom_range(0, 255)));
      end else if (w < 75) begin
        if (held_blocks.size() > 0)
          add_op(MODE_FREE, held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
        else
          add_op(MODE_ALLOC, 8'($urandom_range(0, 255)));
      end else if (w < 85) begin
        add_op(MODE_FREE, 8'($urandom_range(0, 255)));
      end else if (w < 90) begin
        if (plan_pool.pool > 0)
          add_op(MODE_FREE, 8'($urandom_range(0, plan_pool.pool - 1)));
        else
          add_op(MODE_FREE, 8'($urandom_range(0, 255)));
      end else if (w < 95) begin
        add_op(MODE_NOP, 8'($urandom_range(0, 255)));
      end else begin
        add_op(MODE_INIT, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    logic take;
    int   gap;
    take = 1'b0;
    if (rst_n) begin
      case (drv_state)
        DRV_IDLE: take = 1'b1;
        DRV_GAP: begin
          gap_left--;
          if (gap_left == 0) begin
            start_nx  = 1'b1;
            mode_nx   = cur_job.op;
            idx_nx    = cur_job.idx;
            drv_state = DRV_CMD;
          end
        end
        DRV_CMD: begin
          if (cmd_taken) begin
            start_nx = 1'b0;
            take     = 1'b1;
          end
        end
        DRV_DRAIN: begin
          if (reply_forecast.size() == 0 && !busy && !out_valid) begin
            psel_nx    = 1'b1;
            pwrite_nx  = 1'b1;
            pwdata_nx  = cur_job.data;
            drv_state  = DRV_WR_SETUP;
          end
        end
        DRV_WR_SETUP: begin
          penable_nx = 1'b1;
          drv_state  = DRV_WR_ACCESS;
        end
        DRV_WR_ACCESS: begin
          if (bus_done) begin
            penable_nx = 1'b0;
            pwrite_nx  = 1'b0;
            pwdata_nx  = $urandom;
            drv_state  = DRV_RD_SETUP;
          end
        end
        DRV_RD_SETUP: begin
          penable_nx = 1'b1;
          drv_state  = DRV_RD_ACCESS;
        end
        DRV_RD_ACCESS: begin
          if (bus_done) begin
            psel_nx    = 1'b0;
            penable_nx = 1'b0;
            take       = 1'b1;
          end
        end
        default: drv_state = DRV_IDLE;
      endcase
      if (take) begin
        if (op_backlog.size() == 0) begin
          drv_state = DRV_IDLE;
        end else begin
          cur_job = op_backlog.pop_front();
          if (cur_job.is_cfg) begin
            drv_state = DRV_DRAIN;
          end else begin
            if (quiet_run > 0) begin
              gap = 0;
              quiet_run--;
            end else begin
              gap = $urandom_range(0, 15);
              if ($urandom_range(0, 19) == 0) quiet_run = $urandom_range(10, 60);
            end
            if (gap == 0) begin
              start_nx  = 1'b1;
              mode_nx   = cur_job.op;
              idx_nx    = cur_job.idx;
              drv_state = DRV_CMD;
            end else begin
              gap_left  = gap;
              drv_state = DRV_GAP;
            end
          end
        end
      end
    end
    if (!start_nx) begin
      mode_nx = 2'($urandom_range(0, 3));
      idx_nx  = 8'($urandom_range(0, 255));
    end
    start          <= start_nx;
    in_mode        <= mode_nx;
    in_block_index <= idx_nx;
    psel           <= psel_nx;
    penable        <= penable_nx;
    pwrite         <= pwrite_nx;
    paddr          <= ADDR_NUM_BLOCKS;
    pwdata         <= pwdata_nx;
  end

  // monitor and predictor
  always @(posedge clk) begin
    alloc_reply_t want;
    alloc_reply_t next_reply;
    if (!rst_n) begin
      cmd_taken <= 1'b0;
      bus_done  <= 1'b0;
    end else begin
      if (out_valid) begin
        if (reply_forecast.size() == 0) begin
          $error("unexpected reply word: status %0d granted %0d free_count %0d",
                 out_status, out_granted_index, out_free_count);
          fail_count++;
        end else begin
          want = reply_forecast.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_granted_index !== want.granted) begin
            $error("out_granted_index: expected %0d, actual %0d",
                   want.granted, out_granted_index);
            fail_count++;
          end
          if (out_free_count !== want.free_cnt) begin
            $error("out_free_count: expected %0d, actual %0d",
                   want.free_cnt, out_free_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pool_step(live_pool, mode_t'(in_mode), in_block_index, next_reply);
        reply_forecast.push_back(next_reply);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          live_pool.cfg_blocks = pwdata[8:0];
        end else if (prdata !== {23'd0, live_pool.cfg_blocks}) begin
          $error("prdata: expected %0d, actual %0d", live_pool.cfg_blocks, prdata);
          fail_count++;
        end
      end
      cmd_taken <= start && !busy;
      bus_done  <= psel && penable && pready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int phase;
    live_pool = blank_pool();
    plan_pool = blank_pool();

    // before any init, first use, reuse order, top index
    add_op(MODE_NOP, 8'hFF);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_FREE, 8'h00);
    add_op(MODE_INIT, 8'hFF);
    add_op(MODE_ALLOC, 8'h55);
    add_op(MODE_ALLOC, 8'hAA);
    add_op(MODE_FREE, 8'hFF);
    add_op(MODE_FREE, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_NOP, 8'hAA);
    // empty pool
    add_cfg(9'd0);
    add_op(MODE_INIT, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_FREE, 8'h00);
    // single block, double free
    add_cfg(9'd1);
    add_op(MODE_INIT, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_FREE, 8'h00);
    add_op(MODE_FREE, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    add_op(MODE_ALLOC, 8'h00);
    // oversized size saturates
    add_cfg(9'd511);
    add_op(MODE_INIT, 8'h00);
    add_op(MODE_FREE, 8'hFF);

    phase = 0;
    while (item_count < ITEM_TARGET) begin
      if (phase == 3) add_fill_phase();
      else add_random_phase();
      phase++;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (!(op_backlog.size() == 0 && drv_state == DRV_IDLE &&
             reply_forecast.size() == 0))
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
